// File: rtl/isaac_pkg.sv
// ----------------------------------------------------------------------------
// isaac_pkg
// Shared widths, constants and types of the ISAAC random generator.
// ----------------------------------------------------------------------------
package isaac_pkg;

    // memory geometry
    localparam int LOG_WORDS = 8;
    localparam int WORDS     = 1 << LOG_WORDS;
    localparam int HALF      = WORDS / 2;
    localparam int BLK_W     = LOG_WORDS - 3;

    // field widths
    localparam int WORD_W    = 32;
    localparam int OUT_W     = 31;
    localparam int CMD_W     = 2;
    localparam int SEED_IX_W = 8;

    typedef logic [WORD_W-1:0]    t_word;
    typedef logic [LOG_WORDS-1:0] t_addr;
    typedef logic [LOG_WORDS:0]   t_pos;

    // golden ratio seed of the scramble vector
    localparam t_word GOLDEN = 32'h9e37_79b9;

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD = 2'd0,
        CMD_KEY  = 2'd1,
        CMD_DRAW = 2'd2
    } t_cmd;

    // scramble vector operations
    typedef enum logic [2:0] {
        VEC_HOLD,
        VEC_INIT,
        VEC_ADD,
        VEC_STEP,
        VEC_ROT
    } t_vec_op;

    typedef struct packed {
        t_vec_op    op;
        logic [2:0] line;
    } t_vec_ctrl;

endpackage

// File: rtl/isaac_if.sv
// ----------------------------------------------------------------------------
// isaac channel interfaces
// Command channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface isaac_cmd_if;
    import isaac_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CMD_W-1:0]     cmd;
    logic [SEED_IX_W-1:0] seed_index;
    logic [WORD_W-1:0]    seed_word;

    modport source (output valid, output cmd, output seed_index, output seed_word,
                    input ready);
    modport sink   (input valid, input cmd, input seed_index, input seed_word,
                    output ready);
endinterface

interface isaac_out_if;
    import isaac_pkg::*;

    logic             valid;
    logic             ready;
    logic [OUT_W-1:0] random_value;

    modport source (output valid, output random_value, input ready);
    modport sink   (input valid, input random_value, output ready);
endinterface

// File: rtl/isaac_ram.sv
// ----------------------------------------------------------------------------
// isaac_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module isaac_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // read returns the old word on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// File: rtl/isaac_vec.sv
// ----------------------------------------------------------------------------
// isaac_vec
// Eight-word scramble vector, one scramble line per cycle while stepped, rotating lanes.
// ----------------------------------------------------------------------------
module isaac_vec (
    input  logic                  i_clk,
    input  isaac_pkg::t_vec_ctrl  i_ctrl,
    input  isaac_pkg::t_word      i_din,
    output isaac_pkg::t_word      o_w0
);
    import isaac_pkg::*;

    t_word r_w [8];
    t_word n_w [8];
    t_word t0;
    t_word t1;
    t_word t3;

    // shift of one scramble line
    function automatic t_word line_shift(input t_word w, input logic [2:0] line);
        t_word s;
        unique case (line)
            3'd0: s = w << 11;
            3'd1: s = w >> 2;
            3'd2: s = w << 8;
            3'd3: s = w >> 16;
            3'd4: s = w << 10;
            3'd5: s = w >> 4;
            3'd6: s = w << 8;
            3'd7: s = w >> 9;
        endcase
        return s;
    endfunction

    // a step applies one line on the head of the vector, then rotates by one lane
    always_comb begin
        t0 = r_w[0] ^ line_shift(r_w[1], i_ctrl.line);
        t3 = r_w[3] + t0;
        t1 = r_w[1] + r_w[2];
        for (int j = 0; j < 8; j++) begin
            n_w[j] = r_w[j];
        end
        unique case (i_ctrl.op)
            VEC_INIT: begin
                for (int j = 0; j < 8; j++) begin
                    n_w[j] = GOLDEN;
                end
            end
            VEC_ADD: begin
                for (int j = 0; j < 7; j++) begin
                    n_w[j] = r_w[j+1];
                end
                n_w[7] = r_w[0] + i_din;
            end
            VEC_STEP: begin
                n_w[0] = t1;
                n_w[1] = r_w[2];
                n_w[2] = t3;
                n_w[3] = r_w[4];
                n_w[4] = r_w[5];
                n_w[5] = r_w[6];
                n_w[6] = r_w[7];
                n_w[7] = t0;
            end
            VEC_ROT: begin
                for (int j = 0; j < 7; j++) begin
                    n_w[j] = r_w[j+1];
                end
                n_w[7] = r_w[0];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 8; j++) begin
            r_w[j] <= n_w[j];
        end
    end

    assign o_w0 = r_w[0];

endmodule

// File: rtl/isaac_random_generator_core.sv
// ----------------------------------------------------------------------------
// isaac_random_generator_core
// ISAAC generator: seed load, key schedule and draws over two state RAMs.
//
//   channel   dir   handshake        payload
//   i_cmd     in    valid / ready    cmd, seed_index, seed_word
//   o_rnd     out   valid / ready    random_value
//
// A load is written from the idle state; a draw with result words left reads its
// word and goes to the output step. A draw on an empty result RAM first runs a
// round, which makes four mixing RAM accesses for each word on its single read port.
// Key schedule: scrambles of the golden-ratio vector, then two passes over groups of eight words.
// Reset is synchronous; the RAMs are not cleared and the result RAM starts empty.
// A stalled result sits in the output register; the next command is taken.
// ----------------------------------------------------------------------------
module isaac_random_generator_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    isaac_cmd_if.sink   i_cmd,
    isaac_out_if.source o_rnd
);
    import isaac_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_KS_PRE,
        S_AB_READ,
        S_AB_MIX,
        S_AB_WRITE,
        S_RF_RD0,
        S_RF_RD1,
        S_RF_RD2,
        S_RF_Y,
        S_RF_B,
        S_DRAW_RD,
        S_DRAW_OUT
    } t_state;

    t_state           r_state, n_state;
    t_pos             r_rp, n_rp;
    t_word            r_a, n_a;
    t_word            r_b, n_b;
    t_word            r_rc, n_rc;
    logic [3:0]       r_k, n_k;
    logic [1:0]       r_rep, n_rep;
    logic [BLK_W-1:0] r_blk, n_blk;
    logic             r_pass, n_pass;
    t_addr            r_i, n_i;
    t_word            r_x, n_x;
    t_word            r_y, n_y;
    logic             r_fwd, n_fwd;
    logic             r_out_valid, n_out_valid;
    logic [OUT_W-1:0] r_out, n_out;

    // ram ports
    logic      m_we;
    t_addr     m_waddr;
    t_word     m_wdata;
    t_addr     m_raddr;
    t_word     m_rdata;
    logic      res_we;
    t_addr     res_waddr;
    t_word     res_wdata;
    t_addr     res_raddr;
    t_word     res_rdata;

    t_vec_ctrl vec_ctrl;
    t_word     vec_din;
    t_word     vec_w0;
    t_word     y_sum;
    t_addr     y_ix;
    logic      out_free;
    logic      cmd_acc;

    // per-word accumulator shuffle
    function automatic t_word a_shuffle(input t_word a, input logic [1:0] sel);
        t_word s;
        unique case (sel)
            2'd0: s = a ^ (a << 13);
            2'd1: s = a ^ (a >> 6);
            2'd2: s = a ^ (a << 2);
            2'd3: s = a ^ (a >> 16);
        endcase
        return s;
    endfunction

    isaac_ram #(.WIDTH(WORD_W), .DEPTH(WORDS)) u_mix_ram (
        .i_clk   (i_clk),
        .i_we    (m_we),
        .i_waddr (m_waddr),
        .i_wdata (m_wdata),
        .i_raddr (m_raddr),
        .o_rdata (m_rdata)
    );

    isaac_ram #(.WIDTH(WORD_W), .DEPTH(WORDS)) u_res_ram (
        .i_clk   (i_clk),
        .i_we    (res_we),
        .i_waddr (res_waddr),
        .i_wdata (res_wdata),
        .i_raddr (res_raddr),
        .o_rdata (res_rdata)
    );

    isaac_vec u_vec (
        .i_clk  (i_clk),
        .i_ctrl (vec_ctrl),
        .i_din  (vec_din),
        .o_w0   (vec_w0)
    );

    assign i_cmd.ready        = (r_state == S_IDLE);
    assign cmd_acc            = i_cmd.valid && (r_state == S_IDLE);
    assign o_rnd.valid        = r_out_valid;
    assign o_rnd.random_value = r_out;
    assign out_free           = !r_out_valid || o_rnd.ready;

    // refill sum and its indirect index
    assign y_sum = m_rdata + r_a + r_b;
    assign y_ix  = y_sum[2*LOG_WORDS+1:LOG_WORDS+2];

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_rp        = r_rp;
        n_a         = r_a;
        n_b         = r_b;
        n_rc        = r_rc;
        n_k         = r_k;
        n_rep       = r_rep;
        n_blk       = r_blk;
        n_pass      = r_pass;
        n_i         = r_i;
        n_x         = r_x;
        n_y         = r_y;
        n_fwd       = r_fwd;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_rnd.ready;
        m_we        = 1'b0;
        m_waddr     = r_i;
        m_wdata     = y_sum;
        m_raddr     = r_i;
        res_we      = 1'b0;
        res_waddr   = r_i;
        res_wdata   = '0;
        res_raddr   = r_rp[LOG_WORDS-1:0];
        vec_ctrl.op   = VEC_HOLD;
        vec_ctrl.line = r_k[2:0];
        vec_din     = r_pass ? m_rdata : res_rdata;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    unique case (i_cmd.cmd)
                        CMD_LOAD: begin
                            res_we    = 1'b1;
                            res_waddr = i_cmd.seed_index[LOG_WORDS-1:0];
                            res_wdata = i_cmd.seed_word;
                        end
                        CMD_KEY: begin
                            vec_ctrl.op = VEC_INIT;
                            n_a     = '0;
                            n_b     = '0;
                            n_rc    = '0;
                            n_k     = '0;
                            n_rep   = '0;
                            n_state = S_KS_PRE;
                        end
                        CMD_DRAW: begin
                            if (r_rp[LOG_WORDS]) begin
                                n_rc    = r_rc + 32'd1;
                                n_b     = r_b + r_rc + 32'd1;
                                n_i     = '0;
                                n_state = S_RF_RD0;
                            end else begin
                                n_state = S_DRAW_OUT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            // four scrambles of the golden-ratio vector
            S_KS_PRE: begin
                vec_ctrl.op = VEC_STEP;
                n_k = r_k + 4'd1;
                if (r_k[2:0] == 3'd7) begin
                    n_k   = '0;
                    n_rep = r_rep + 2'd1;
                    if (r_rep == 2'd3) begin
                        n_blk   = '0;
                        n_pass  = 1'b0;
                        n_state = S_AB_READ;
                    end
                end
            end
            // stream eight source words into the vector
            S_AB_READ: begin
                m_raddr   = {r_blk, r_k[2:0]};
                res_raddr = {r_blk, r_k[2:0]};
                if (r_k != 4'd0) begin
                    vec_ctrl.op = VEC_ADD;
                end
                if (r_k == 4'd8) begin
                    n_k     = '0;
                    n_state = S_AB_MIX;
                end else begin
                    n_k = r_k + 4'd1;
                end
            end
            S_AB_MIX: begin
                vec_ctrl.op = VEC_STEP;
                if (r_k[2:0] == 3'd7) begin
                    n_k     = '0;
                    n_state = S_AB_WRITE;
                end else begin
                    n_k = r_k + 4'd1;
                end
            end
            // write the vector back to the mixing ram
            S_AB_WRITE: begin
                vec_ctrl.op = VEC_ROT;
                m_we    = 1'b1;
                m_waddr = {r_blk, r_k[2:0]};
                m_wdata = vec_w0;
                if (r_k[2:0] == 3'd7) begin
                    n_k = '0;
                    if (r_blk == '1) begin
                        n_blk = '0;
                        if (r_pass) begin
                            n_rp    = t_pos'(WORDS);
                            n_state = S_IDLE;
                        end else begin
                            n_pass  = 1'b1;
                            n_state = S_AB_READ;
                        end
                    end else begin
                        n_blk   = r_blk + 1'b1;
                        n_state = S_AB_READ;
                    end
                end else begin
                    n_k = r_k + 4'd1;
                end
            end
            // round: fetch x
            S_RF_RD0: begin
                m_raddr = r_i;
                n_state = S_RF_RD1;
            end
            S_RF_RD1: begin
                n_x     = m_rdata;
                m_raddr = r_i + t_addr'(HALF);
                n_state = S_RF_RD2;
            end
            S_RF_RD2: begin
                n_a     = m_rdata + a_shuffle(r_a, r_i[1:0]);
                m_raddr = r_x[LOG_WORDS+1:2];
                n_state = S_RF_Y;
            end
            // y goes back in place; its indirect read may hit the same entry
            S_RF_Y: begin
                m_we    = 1'b1;
                m_waddr = r_i;
                m_wdata = y_sum;
                m_raddr = y_ix;
                n_y     = y_sum;
                n_fwd   = (y_ix == r_i);
                n_state = S_RF_B;
            end
            S_RF_B: begin
                n_b       = (r_fwd ? r_y : m_rdata) + r_x;
                res_we    = 1'b1;
                res_waddr = r_i;
                res_wdata = n_b;
                if (r_i == '1) begin
                    n_rp    = '0;
                    n_state = S_DRAW_RD;
                end else begin
                    n_i     = r_i + 1'b1;
                    m_raddr = r_i + 1'b1;
                    n_state = S_RF_RD1;
                end
            end
            S_DRAW_RD: begin
                n_state = S_DRAW_OUT;
            end
            // hand the word to the output register once it is free
            S_DRAW_OUT: begin
                if (out_free) begin
                    n_out       = res_rdata[OUT_W-1:0];
                    n_out_valid = 1'b1;
                    n_rp        = r_rp + 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rp        <= t_pos'(WORDS);
            r_a         <= '0;
            r_b         <= '0;
            r_rc        <= '0;
            r_k         <= '0;
            r_rep       <= '0;
            r_blk       <= '0;
            r_pass      <= 1'b0;
            r_i         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rp        <= n_rp;
            r_a         <= n_a;
            r_b         <= n_b;
            r_rc        <= n_rc;
            r_k         <= n_k;
            r_rep       <= n_rep;
            r_blk       <= n_blk;
            r_pass      <= n_pass;
            r_i         <= n_i;
            r_out_valid <= n_out_valid;
        end
        r_x   <= n_x;
        r_y   <= n_y;
        r_fwd <= n_fwd;
        r_out <= n_out;
    end

    // a draw with words left goes straight to the output step
    a_draw_direct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_acc && (i_cmd.cmd == CMD_DRAW) && !r_rp[LOG_WORDS] |=> r_state == S_DRAW_OUT)
        else $error("draw with words left did not reach output step");

    // the key schedule leaves the result ram empty
    a_ks_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) && ($past(r_state) == S_AB_WRITE) |-> r_rp == t_pos'(WORDS))
        else $error("key schedule ended without emptying result ram");

    // a result only appears out of the output step
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_DRAW_OUT)
        else $error("result item raised outside the output step");

    // the mixing ram is left alone while idle or drawing
    a_mix_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) || (r_state == S_DRAW_RD) || (r_state == S_DRAW_OUT) |-> !m_we)
        else $error("mixing ram written outside a round or key schedule");

    // the last word of a round leads to the draw read
    a_round_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RF_B) && (r_i == '1) |=> (r_state == S_DRAW_RD) && (r_rp == '0))
        else $error("round end did not rewind read position");

endmodule
